// File: src/cnfs_pkg.sv
// ----------------------------------------------------------------------------
// Circular next-free slot allocator package
// Shared widths, command and status codes, sequencer states and bundles.
// ----------------------------------------------------------------------------
package cnfs_pkg;

	localparam int SLOT_W    = 11;
	localparam int SLOTS_DEF = 1024;

	localparam logic [SLOT_W-1:0] SLOT_COUNT_RST = 11'd1024;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic STATUS_GRANTED = 1'b0;
	localparam logic STATUS_FULL    = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UP,
		ST_DOWN,
		ST_GRANT,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic              status;
	} result_t;

	typedef struct packed {
		logic re;
		logic we;
	} mem_ctl_t;

endpackage

// File: src/cnfs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one allocate or release command per beat.
// ----------------------------------------------------------------------------
interface cnfs_req_if;
	import cnfs_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, cmd, slot, input ready);
	modport sink   (input valid, cmd, slot, output ready);
endinterface

// File: src/cnfs_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one granted slot and status per beat.
// ----------------------------------------------------------------------------
interface cnfs_rsp_if;
	import cnfs_pkg::*;

	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] granted_slot;
	logic              status;

	modport source (output valid, granted_slot, status, input ready);
	modport sink   (input valid, granted_slot, status, output ready);
endinterface

// File: src/circular_next_free_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Circular next-free slot allocator
// Grants the preferred slot or the next free one after it, wrapping around.
// ----------------------------------------------------------------------------
// The req channel takes one beat per command: cmd selects allocate or
// release, slot is the 1-based preferred slot or the slot to free. Every
// allocate produces one beat on the rsp channel with the granted slot and a
// status that is set when no usable slot is free; releases produce nothing.
// cfg_we with cfg_wdata sets the number of usable slots; write it only while
// no command is in flight.
// Occupancy lives in a tree of full flags in one memory, one level visited
// per cycle. An allocate goes through acceptance, one climb and descent, a
// second descent from the root on wrap-around, the hand-over of the result
// and, when a slot is granted, the walk back up that updates the flags; a
// release of an in-range slot does only that walk. The update stops early
// at the first level whose full flag does not change.
// After reset the block clears every tree memory entry, one entry per cycle,
// with req.ready low.
// A finished result sits in an output register; a stalled receiver only
// holds the block once a second result is ready to be handed over.
// ----------------------------------------------------------------------------
module circular_next_free_slot_allocator_core #(
	parameter int SLOTS = cnfs_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cnfs_pkg::SLOT_W-1:0] cfg_wdata,
	cnfs_req_if.sink                    req,
	cnfs_rsp_if.source                  rsp
);
	import cnfs_pkg::*;

	localparam int LW = $clog2(SLOTS);

	logic [SLOT_W-1:0] slot_count_q;
	logic              rsp_vld_q;
	result_t           rsp_q;

	logic              res_valid;
	logic              res_take;
	result_t           res;
	mem_ctl_t          mem_ctl;
	logic [LW-1:0]     mem_raddr;
	logic [LW-1:0]     mem_waddr;
	logic [1:0]        mem_wdata;
	logic [1:0]        mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	assign res_take = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.granted_slot = rsp_q.granted_slot;
	assign rsp.status       = rsp_q.status;

	cnfs_seq #(
		.SLOTS (SLOTS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_count (slot_count_q),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_cmd    (req.cmd),
		.req_slot   (req.slot),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.mem_ctl    (mem_ctl),
		.mem_raddr  (mem_raddr),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	cnfs_tree_mem #(
		.AW (LW)
	) u_tree_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.raddr (mem_raddr),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

// File: src/cnfs_tree_mem.sv
// ----------------------------------------------------------------------------
// Occupancy tree memory
// One entry per inner node, holding the full flags of its two children.
// ----------------------------------------------------------------------------
module cnfs_tree_mem #(
	parameter int AW = 10
) (
	input  logic               clk,
	input  cnfs_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]      raddr,
	input  logic [AW-1:0]      waddr,
	input  logic [1:0]         wdata,
	output logic [1:0]         rdata
);
	import cnfs_pkg::*;

	logic [1:0] mem [2**AW];
	logic [1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/cnfs_seq.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the occupancy tree one level per cycle to search on an allocate, then to update.
// ----------------------------------------------------------------------------
module cnfs_seq #(
	parameter int SLOTS = cnfs_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cnfs_pkg::SLOT_W-1:0]   slot_count,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          req_cmd,
	input  logic [cnfs_pkg::SLOT_W-1:0]   req_slot,
	output logic                          res_valid,
	input  logic                          res_take,
	output cnfs_pkg::result_t             res,
	output cnfs_pkg::mem_ctl_t            mem_ctl,
	output logic [$clog2(SLOTS)-1:0]      mem_raddr,
	output logic [$clog2(SLOTS)-1:0]      mem_waddr,
	output logic [1:0]                    mem_wdata,
	input  logic [1:0]                    mem_rdata
);
	import cnfs_pkg::*;

	localparam int LW = $clog2(SLOTS);
	localparam int NW = LW + 1;
	localparam int CW = (NW > SLOT_W) ? NW : SLOT_W;
	localparam logic [NW-1:0] ROOT = NW'(1);

	state_t        state_q, state_d;
	logic [LW-1:0] clr_q;
	logic [NW-1:0] x_q;
	logic          pass_q;
	logic          set_q;
	result_t       res_q;

	logic [CW-1:0] n_slots;
	logic [CW-1:0] slot_ext;
	logic [CW-1:0] slot_m1;
	logic          in_range;
	logic [NW-1:0] lo_leaf;
	logic [NW-1:0] up_e;
	logic [NW-1:0] sib;
	logic [NW-1:0] down_child;

	logic          step_found;
	logic          step_none;
	logic          step_climb;
	logic [NW-1:0] step_node;
	logic          leaf_ok;
	logic          step_hit;
	logic          step_miss;

	logic [1:0]    upd_mask;
	logic [1:0]    upd_bits;
	logic          upd_cont;

	always_comb begin
		n_slots  = (CW'(slot_count) < CW'(SLOTS)) ? CW'(slot_count) : CW'(SLOTS);
		slot_ext = CW'(req_slot);
		slot_m1  = slot_ext - CW'(1);
		in_range = (req_slot != '0) && (slot_ext <= n_slots);
		lo_leaf  = in_range ? {1'b1, slot_m1[LW-1:0]} : {1'b1, LW'(0)};
		up_e       = {1'b0, x_q[NW-1:1]};
		sib        = x_q | NW'(1);
		down_child = {x_q[LW-1:0], mem_rdata[0]};
	end

	// One step of the search on the entry that was read in the last cycle.
	always_comb begin
		step_found = 1'b0;
		step_none  = 1'b0;
		step_climb = 1'b0;
		step_node  = up_e;
		case (state_q)
			ST_UP: begin
				if (x_q[LW] && !mem_rdata[x_q[0]]) begin
					step_found = 1'b1;
					step_node  = x_q;
				end else if (!x_q[0] && !mem_rdata[1]) begin
					step_found = sib[LW];
					step_node  = sib;
				end else if (up_e == ROOT) begin
					step_none = 1'b1;
				end else begin
					step_climb = 1'b1;
					step_node  = up_e;
				end
			end
			ST_DOWN: begin
				if (&mem_rdata) begin
					step_none = 1'b1;
				end else begin
					step_found = down_child[LW];
					step_node  = down_child;
				end
			end
			default: begin
				step_node = up_e;
			end
		endcase
		leaf_ok   = CW'(step_node[LW-1:0]) < n_slots;
		step_hit  = step_found && leaf_ok;
		step_miss = step_none || (step_found && !leaf_ok);
	end

	always_comb begin
		upd_mask = x_q[0] ? 2'b10 : 2'b01;
		upd_bits = set_q ? (mem_rdata | upd_mask) : (mem_rdata & ~upd_mask);
		upd_cont = ((&mem_rdata) != (&upd_bits)) && (up_e != ROOT);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req_cmd == CMD_ALLOC) begin
						state_d = ST_UP;
					end else if (in_range) begin
						state_d = ST_UPD;
					end
				end
			end
			ST_UP, ST_DOWN: begin
				if (step_hit) begin
					state_d = ST_GRANT;
				end else if (step_miss) begin
					state_d = pass_q ? ST_GRANT : ST_DOWN;
				end else begin
					state_d = step_climb ? ST_UP : ST_DOWN;
				end
			end
			ST_GRANT: begin
				if (res_take) begin
					state_d = (res_q.status == STATUS_FULL) ? ST_IDLE : ST_UPD;
				end
			end
			ST_UPD: begin
				if (!upd_cont) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		res_valid  = (state_q == ST_GRANT);
		mem_ctl    = '0;
		mem_raddr  = step_node[LW-1:0];
		mem_waddr  = up_e[LW-1:0];
		mem_wdata  = upd_bits;
		case (state_q)
			ST_CLEAR: begin
				mem_ctl.we = 1'b1;
				mem_waddr  = clr_q;
				mem_wdata  = 2'b00;
			end
			ST_IDLE: begin
				mem_ctl.re = req_valid;
				mem_raddr  = lo_leaf[NW-1:1];
			end
			ST_UP, ST_DOWN: begin
				if (step_miss) begin
					mem_ctl.re = !pass_q;
					mem_raddr  = ROOT[LW-1:0];
				end else if (!step_hit) begin
					mem_ctl.re = 1'b1;
					mem_raddr  = step_climb ? up_e[NW-1:1] : step_node[LW-1:0];
				end
			end
			ST_GRANT: begin
				mem_ctl.re = res_take && (res_q.status == STATUS_GRANTED);
				mem_raddr  = x_q[NW-1:1];
			end
			ST_UPD: begin
				mem_ctl.we = 1'b1;
				mem_ctl.re = upd_cont;
				mem_raddr  = up_e[NW-1:1];
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= lo_leaf;
				pass_q <= 1'b0;
				set_q  <= (req_cmd == CMD_ALLOC);
			end
			ST_UP, ST_DOWN: begin
				if (step_hit) begin
					x_q   <= step_node;
					res_q <= '{granted_slot: SLOT_W'(CW'(step_node[LW-1:0]) + CW'(1)),
					           status: STATUS_GRANTED};
				end else if (step_miss) begin
					if (!pass_q) begin
						pass_q <= 1'b1;
						x_q    <= ROOT;
					end else begin
						res_q <= '{granted_slot: '0, status: STATUS_FULL};
					end
				end else begin
					x_q <= step_node;
				end
			end
			ST_UPD: begin
				x_q <= up_e;
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign res = res_q;

`ifndef ASSERT_OFF
	a_grant_is_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GRANT && res_q.status == STATUS_GRANTED) |-> x_q[LW])
		else $error("granted node is not a leaf");

	a_descend_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOWN && mem_rdata == 2'b11) |-> (x_q == ROOT))
		else $error("descent entered a full inner node");

	a_upd_addr_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (up_e != '0))
		else $error("update walked above the root");

	a_grant_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GRANT && !res_take) |=> (state_q == ST_GRANT && $stable(res_q)))
		else $error("result changed while waiting for the output register");
`endif

endmodule

// File: tb/tb_circular_next_free_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Testbench for the circular next-free slot allocator
// Drives allocate and release beats under random sender gaps and receiver
// stalls, keeps its own occupancy map to predict every granted slot, and
// compares each response beat with the oldest prediction. The slot count is
// changed between phases, from zero up to values beyond the slot array.
// ----------------------------------------------------------------------------
module tb_circular_next_free_slot_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cnfs_pkg::*;

	localparam int SLOTS         = SLOTS_DEF;
	localparam int GUARD_CYCLES  = 600000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASES        = 12;
	localparam int PHASE_BEATS   = 102;

	class slot_scoreboard;
		bit          taken [SLOTS];
		int unsigned slot_count;
		result_t     grants_due [$];
		int unsigned errors;
		int unsigned allocs;
		int unsigned fulls;
		int unsigned releases;
		int unsigned grants_seen;

		function new();
			slot_count = SLOT_COUNT_RST;
		endfunction

		function int unsigned usable();
			return (slot_count < SLOTS) ? slot_count : SLOTS;
		endfunction

		function int unsigned pick_taken();
			int unsigned n;
			int unsigned first;
			int unsigned p;
			n = usable();
			if (n == 0) begin
				return 0;
			end
			first = $urandom_range(0, n - 1);
			for (int unsigned k = 0; k < n; k++) begin
				p = (first + k) % n;
				if (taken[p]) begin
					return p + 1;
				end
			end
			return 0;
		endfunction

		function void note_request(logic cmd, logic [SLOT_W-1:0] slot);
			int unsigned n;
			int unsigned s;
			int unsigned first;
			int unsigned p;
			bit          in_range;
			result_t     want;
			n = usable();
			s = slot;
			in_range = (s >= 1) && (s <= n);
			if (cmd == CMD_RELEASE) begin
				releases++;
				if (in_range) begin
					taken[s - 1] = 1'b0;
				end
				return;
			end
			allocs++;
			want.granted_slot = '0;
			want.status = STATUS_FULL;
			first = in_range ? s - 1 : 0;
			for (int unsigned k = 0; k < n; k++) begin
				p = first + k;
				if (p >= n) begin
					p -= n;
				end
				if (!taken[p]) begin
					taken[p] = 1'b1;
					want.granted_slot = SLOT_W'(p + 1);
					want.status = STATUS_GRANTED;
					break;
				end
			end
			if (want.status == STATUS_FULL) begin
				fulls++;
			end
			grants_due.push_back(want);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (grants_due.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat: expected none, actual slot %0d status %0d",
					$time, got.granted_slot, got.status);
				return;
			end
			want = grants_due.pop_front();
			grants_seen++;
			if (got.granted_slot !== want.granted_slot) begin
				errors++;
				$display("%0t granted_slot mismatch: expected %0d, actual %0d",
					$time, want.granted_slot, got.granted_slot);
			end
			if (got.status !== want.status) begin
				errors++;
				$display("%0t status mismatch: expected %0d, actual %0d",
					$time, want.status, got.status);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SLOT_W-1:0] cfg_wdata;

	cnfs_req_if req_ch ();
	cnfs_rsp_if rsp_ch ();

	slot_scoreboard sb;
	bit             send_calm;
	bit             rsp_calm;
	bit             hold_request;
	int unsigned    cycles;
	int unsigned    settings;

	circular_next_free_slot_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > GUARD_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin : monitor
		result_t got;
		if (arst_n === 1'b1) begin
			if (req_ch.valid && req_ch.ready) begin
				sb.note_request(req_ch.cmd, req_ch.slot);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.granted_slot = rsp_ch.granted_slot;
				got.status = rsp_ch.status;
				sb.check_result(got);
			end
		end
	end

	// The receiver may stall for a random stretch after an accepted beat, or for a long stretch on request.
	initial begin : receiver
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		rsp_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			stall = 0;
			if (rsp_ch.valid && rsp_ch.ready && !rsp_calm) begin
				stall = $urandom_range(0, 19);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_beat(input logic cmd, input logic [SLOT_W-1:0] slot);
		int unsigned gap;
		gap = send_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.slot <= slot;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
	endtask

	task automatic wait_for_grants();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.grants_due.size() != 0);
	endtask

	task automatic write_slot_count(input logic [SLOT_W-1:0] value);
		wait_for_grants();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.slot_count = value;
		settings++;
	endtask

	task automatic random_beat(input int unsigned alloc_pct);
		int unsigned       n;
		int unsigned       roll;
		int unsigned       pick;
		logic [SLOT_W-1:0] s;
		n = sb.usable();
		roll = $urandom_range(0, 99);
		if (roll >= 92) begin
			send_beat(1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 2047)));
		end else if (roll < alloc_pct * 92 / 100) begin
			roll = $urandom_range(0, 9);
			pick = sb.pick_taken();
			if (n == 0 || roll >= 8) begin
				s = SLOT_W'($urandom_range(0, 2047));
			end else if (roll >= 5 && pick != 0) begin
				s = SLOT_W'(pick);
			end else begin
				s = SLOT_W'($urandom_range(1, n));
			end
			send_beat(CMD_ALLOC, s);
		end else begin
			pick = sb.pick_taken();
			if (pick == 0 || $urandom_range(0, 9) == 0) begin
				s = SLOT_W'($urandom_range(0, 2047));
			end else begin
				s = SLOT_W'(pick);
			end
			send_beat(CMD_RELEASE, s);
		end
	endtask

	initial begin : stimulus
		logic [SLOT_W-1:0] counts [PHASES];
		int unsigned       alloc_pct;
		sb = new();
		cycles = 0;
		settings = 0;
		send_calm = 1'b0;
		rsp_calm = 1'b0;
		hold_request = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_ALLOC;
		req_ch.slot <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_beat(CMD_ALLOC, 11'd1);
		send_beat(CMD_ALLOC, 11'd1);
		send_beat(CMD_ALLOC, 11'd1024);
		send_beat(CMD_ALLOC, 11'd1024);
		send_beat(CMD_ALLOC, 11'd0);
		send_beat(CMD_ALLOC, 11'd2047);
		send_beat(CMD_ALLOC, 11'd1365);
		send_beat(CMD_RELEASE, 11'd1);
		send_beat(CMD_RELEASE, 11'd1);
		send_beat(CMD_RELEASE, 11'd0);
		send_beat(CMD_RELEASE, 11'd2047);
		send_beat(CMD_RELEASE, 11'd682);
		send_beat(CMD_RELEASE, 11'd1024);
		send_beat(CMD_ALLOC, 11'd1023);
		send_beat(CMD_ALLOC, 11'd1023);
		send_beat(CMD_ALLOC, 11'd1023);
		write_slot_count(11'd2);
		send_beat(CMD_ALLOC, 11'd2);
		send_beat(CMD_ALLOC, 11'd2);
		send_beat(CMD_ALLOC, 11'd2);
		send_beat(CMD_RELEASE, 11'd3);
		send_beat(CMD_ALLOC, 11'd0);
		write_slot_count(11'd0);
		send_beat(CMD_ALLOC, 11'd1);
		send_beat(CMD_RELEASE, 11'd1);

		counts = '{11'd3, 11'd2047, 11'd16, 11'd1, 11'd100, 11'd0,
			11'd1024, 11'd2, 11'd64, 11'd700, 11'd5, 11'd1024};
		counts[9] = SLOT_W'($urandom_range(1, 1024));
		for (int p = 0; p < PHASES; p++) begin
			write_slot_count(counts[p]);
			alloc_pct = (p % 3 == 0) ? 80 : ((p % 3 == 1) ? 45 : 62);
			send_calm = ($urandom_range(0, 3) == 0);
			rsp_calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if (p == 2 && i == 20) begin
					hold_request = 1'b1;
				end
				if (p == 4 && i == 50) begin
					wait_for_grants();
				end
				random_beat(alloc_pct);
			end
		end

		wait_for_grants();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d allocates (%0d with no free slot) and %0d releases over %0d slot counts.",
			sb.allocs, sb.fulls, sb.releases, settings);
		$display("Compared %0d result beats, %0d field mismatches.", sb.grants_seen, sb.errors);
		if (sb.errors == 0 && sb.grants_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
